@@ sv/tkmd_pkg.sv @@
// Shared types, codes and helper functions for the terminal key and mouse decoder.
package tkmd_pkg;

	localparam int unsigned BODY_LIMIT_DEF = 32;
	localparam int unsigned LEN_W          = 6;
	localparam int unsigned KIND_W         = 4;

	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_CTRL_C = 8'h03;
	localparam logic [7:0] CH_LBRK   = 8'h5b;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_M   = 8'h4d;
	localparam logic [7:0] CH_LO_M   = 8'h6d;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_B   = 8'h42;
	localparam logic [7:0] CH_UP_C   = 8'h43;
	localparam logic [7:0] CH_UP_D   = 8'h44;

	localparam logic [KIND_W-1:0] EV_QUIT      = 4'd0;
	localparam logic [KIND_W-1:0] EV_PLAYPAUSE = 4'd1;
	localparam logic [KIND_W-1:0] EV_PREV      = 4'd2;
	localparam logic [KIND_W-1:0] EV_PLAY      = 4'd3;
	localparam logic [KIND_W-1:0] EV_STOP      = 4'd4;
	localparam logic [KIND_W-1:0] EV_NEXT      = 4'd5;
	localparam logic [KIND_W-1:0] EV_VOLUP     = 4'd6;
	localparam logic [KIND_W-1:0] EV_VOLDOWN   = 4'd7;
	localparam logic [KIND_W-1:0] EV_SEEKFWD   = 4'd8;
	localparam logic [KIND_W-1:0] EV_SEEKBACK  = 4'd9;
	localparam logic [KIND_W-1:0] EV_MOUSE     = 4'd10;
	localparam logic [KIND_W-1:0] EV_NONE      = 4'd15;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_ESC  = 4'b0010,
		PH_CSI  = 4'b0100,
		PH_BODY = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        button;
		logic [15:0]       col;
		logic [15:0]       row;
		logic              press;
	} result_t;

	function automatic logic [KIND_W-1:0] key_event(input logic [7:0] b);
		logic [KIND_W-1:0] ev;
		unique case (b)
			8'h71, 8'h51, CH_CTRL_C: ev = EV_QUIT;
			8'h20, 8'h63, 8'h43:     ev = EV_PLAYPAUSE;
			8'h7a, 8'h5a:            ev = EV_PREV;
			8'h78, 8'h58:            ev = EV_PLAY;
			8'h76, 8'h56:            ev = EV_STOP;
			8'h62, 8'h42:            ev = EV_NEXT;
			8'h2b, 8'h3d:            ev = EV_VOLUP;
			8'h2d, 8'h5f:            ev = EV_VOLDOWN;
			default:                 ev = EV_NONE;
		endcase
		return ev;
	endfunction

	function automatic logic [7:0] sat_digit8(input logic [7:0] acc, input logic [3:0] d);
		logic [11:0] v;
		v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {8'd0, d};
		return (v > 12'd255) ? 8'hff : v[7:0];
	endfunction

	function automatic logic [15:0] sat_digit16(input logic [15:0] acc, input logic [3:0] d);
		logic [19:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
		return (v > 20'd65535) ? 16'hffff : v[15:0];
	endfunction

endpackage

@@ sv/tkmd_parse.sv @@
// Input register, sequence parser state and per-byte event decode.
module tkmd_parse import tkmd_pkg::*; #(
	parameter int unsigned BODY_LIMIT = BODY_LIMIT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic [7:0] in_byte,
	input  logic    res_take,
	output logic    res_valid,
	output result_t res
);

	localparam logic [LEN_W-1:0] LIMIT = LEN_W'(BODY_LIMIT);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;

	phase_t           phase_q, phase_d;
	logic [1:0]       fidx_q, fidx_d;
	logic             has_digit_q, has_digit_d;
	logic             bad_q, bad_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0]       button_q, button_d;
	logic [15:0]      col_q, col_d;
	logic [15:0]      row_q, row_d;

	logic [KIND_W-1:0] ev;
	logic              press;
	logic              is_digit;
	logic [3:0]        digit;

	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit    = 4'(byte_s1 - CH_ZERO);

	always_comb begin
		phase_d     = phase_q;
		fidx_d      = fidx_q;
		has_digit_d = has_digit_q;
		bad_d       = bad_q;
		len_d       = len_q;
		button_d    = button_q;
		col_d       = col_q;
		row_d       = row_q;
		ev          = EV_NONE;
		press       = 1'b0;
		unique case (phase_q)
			PH_ESC: begin
				if (byte_s1 == CH_LBRK) begin
					phase_d = PH_CSI;
				end else if (byte_s1 == CH_ESC) begin
					phase_d = PH_ESC;
				end else begin
					phase_d = PH_IDLE;
					ev      = key_event(byte_s1);
				end
			end
			PH_CSI: begin
				phase_d = PH_IDLE;
				priority if (byte_s1 == CH_LT) begin
					phase_d     = PH_BODY;
					fidx_d      = '0;
					has_digit_d = 1'b0;
					bad_d       = 1'b0;
					len_d       = '0;
					button_d    = '0;
					col_d       = '0;
					row_d       = '0;
				end else if (byte_s1 == CH_UP_A) begin
					ev = EV_VOLUP;
				end else if (byte_s1 == CH_UP_B) begin
					ev = EV_VOLDOWN;
				end else if (byte_s1 == CH_UP_C) begin
					ev = EV_SEEKFWD;
				end else if (byte_s1 == CH_UP_D) begin
					ev = EV_SEEKBACK;
				end else begin
					ev = EV_NONE;
				end
			end
			PH_BODY: begin
				if (byte_s1 == CH_UP_M || byte_s1 == CH_LO_M) begin
					if (!bad_q && fidx_q == 2'd2 && has_digit_q) begin
						ev    = EV_MOUSE;
						press = (byte_s1 == CH_UP_M);
					end
					phase_d = PH_IDLE;
				end else begin
					if (len_q >= LIMIT) begin
						bad_d = 1'b1;
					end else begin
						len_d = len_q + 1'b1;
					end
					priority if (is_digit) begin
						unique case (fidx_q)
							2'd0:    button_d = sat_digit8(button_q, digit);
							2'd1:    col_d    = sat_digit16(col_q, digit);
							default: row_d    = sat_digit16(row_q, digit);
						endcase
						has_digit_d = 1'b1;
					end else if (byte_s1 == CH_SEMI) begin
						if (!has_digit_q || fidx_q >= 2'd2) begin
							bad_d = 1'b1;
						end else begin
							fidx_d      = fidx_q + 1'b1;
							has_digit_d = 1'b0;
						end
					end else begin
						bad_d = 1'b1;
					end
				end
			end
			default: begin
				if (byte_s1 == CH_ESC) begin
					phase_d = PH_ESC;
				end else begin
					phase_d = PH_IDLE;
					ev      = key_event(byte_s1);
				end
			end
		endcase
	end

	assign res_valid  = valid_s1 && (ev != EV_NONE);
	assign res.kind   = ev;
	assign res.button = (ev == EV_MOUSE) ? button_q : 8'd0;
	assign res.col    = (ev == EV_MOUSE) ? col_q : 16'd0;
	assign res.row    = (ev == EV_MOUSE) ? row_q : 16'd0;
	assign res.press  = press;

	assign advance  = valid_s1 && (res_take || (ev == EV_NONE));
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			fidx_q      <= '0;
			has_digit_q <= 1'b0;
			bad_q       <= 1'b0;
			len_q       <= '0;
			button_q    <= '0;
			col_q       <= '0;
			row_q       <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			fidx_q      <= fidx_d;
			has_digit_q <= has_digit_d;
			bad_q       <= bad_d;
			len_q       <= len_d;
			button_q    <= button_d;
			col_q       <= col_d;
			row_q       <= row_d;
		end
	end

endmodule

@@ sv/tkmd_result.sv @@
// Result register holding one decoded event until the receiver takes it.
module tkmd_result import tkmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  result_t           res,
	output logic              res_take,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] event_kind,
	output logic [7:0]        mouse_button,
	output logic [15:0]       mouse_col,
	output logic [15:0]       mouse_row,
	output logic              mouse_press
);

	logic    valid_q;
	result_t data_q;

	assign res_take = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_take) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			data_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign event_kind   = data_q.kind;
	assign mouse_button = data_q.button;
	assign mouse_col    = data_q.col;
	assign mouse_row    = data_q.row;
	assign mouse_press  = data_q.press;

endmodule

@@ sv/terminal_key_mouse_decoder_core.sv @@
// Top level of the terminal key and mouse decoder.
//
// Input channel: one terminal byte per request on in_byte, moved when in_valid
// is high and in_stall is low. Output channel: one event per request on
// event_kind and the mouse fields, moved when out_valid is high and out_stall
// is low. Mouse fields read zero for events other than a mouse report.
// A byte is held in the input register, where the parser decodes it and
// updates its state; an event it causes is loaded into the output register
// once that register is free to take it.
// Throughput is one byte per cycle unless an event waits on a stalled receiver.
// Bytes that cause no event retire without using the output register.
// When the receiver stalls, the held event stays put and one more byte may
// enter the input register; a byte that would cause another event then waits
// there and in_stall rises until the output register frees.
// Reset clears both registers' valid flags and returns the parser to idle
// with no sequence open and all mouse fields cleared.
module terminal_key_mouse_decoder_core import tkmd_pkg::*; #(
	parameter int unsigned BODY_LIMIT = BODY_LIMIT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] event_kind,
	output logic [7:0]        mouse_button,
	output logic [15:0]       mouse_col,
	output logic [15:0]       mouse_row,
	output logic              mouse_press
);

	logic    res_valid;
	logic    res_take;
	result_t res;

	tkmd_parse #(
		.BODY_LIMIT(BODY_LIMIT)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.res_take  (res_take),
		.res_valid (res_valid),
		.res       (res)
	);

	tkmd_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.mouse_button (mouse_button),
		.mouse_col    (mouse_col),
		.mouse_row    (mouse_row),
		.mouse_press  (mouse_press)
	);

endmodule
